// File: rtl/aspsch_pkg.sv
// Shared constants for the sensor poll scheduler.
// No dependencies.
package aspsch_pkg;

    localparam int          ENTRIES_DEF = 28;  // number of sensor slots
    localparam int          SLOT_W      = 5;   // slot field width on the ports
    localparam int          LIMIT_W     = 8;   // retry limit / counter width
    localparam logic [7:0]  LIMIT_RST   = 8'd2;

endpackage

// File: rtl/active_sensor_poll_scheduler_top.sv
// Sensor poll scheduler: retry counter memory, dynamic and idle slot scans.
// Depends on aspsch_pkg.
//
// Each input word is either a sensor-answered event (tuser = 0), which loads
// that slot's retry counter with the retry limit and gives no output, or a
// poll request (tuser = 1), which gives one output word with the chosen slot.
// Counters live in a synchronous memory read one slot per cycle; in dynamic
// phase a poll request scans from the dynamic pointer to the end of the table,
// and if nothing is found there, over all ENTRIES slots from the idle pointer;
// out of dynamic phase it goes straight to the idle scan. The slowest request
// is one whose dynamic pass from slot 0 finds nothing, so that a full idle scan
// follows; the cost is set by the one-read-per-cycle memory port, and the input
// is ready again as the output register is loaded. One word is processed at a
// time; a new word is taken while the previous result waits in the output
// register. Counters read as zero until first written, so no clearing pass
// follows reset.
module active_sensor_poll_scheduler_top
    import aspsch_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration: retry limit
    input  logic               i_cfg_wr_en,
    input  logic [LIMIT_W-1:0] i_cfg_wr_data,
    // input stream
    input  logic               i_s_axis_tvalid,
    output logic               o_s_axis_tready,
    input  logic [7:0]         i_s_axis_tdata,   // [4:0] sensor_slot
    input  logic               i_s_axis_tuser,   // [0] kind
    // output stream
    output logic               o_m_axis_tvalid,
    input  logic               i_m_axis_tready,
    output logic [7:0]         o_m_axis_tdata,   // [4:0] poll_slot
    output logic               o_m_axis_tuser    // [0] none_found
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {S_IDLE, S_DYN, S_IDL, S_OUT} t_state;

    // registers
    t_state             r_state,     n_state;
    logic [LIMIT_W-1:0] r_limit;
    logic [ENTRIES-1:0] r_vld,       n_vld;
    logic [IW-1:0]      r_dyn_ptr,   n_dyn_ptr;
    logic [CW-1:0]      r_idle_ptr,  n_idle_ptr;
    logic               r_dyn_phase, n_dyn_phase;
    logic [CW-1:0]      r_served,    n_served;
    logic [IW-1:0]      r_iss_addr,  n_iss_addr;
    logic [CW-1:0]      r_iss_left,  n_iss_left;
    logic               r_pend,      n_pend;
    logic [IW-1:0]      r_pidx;
    logic [SLOT_W-1:0]  r_res_slot,  n_res_slot;
    logic               r_res_none,  n_res_none;
    logic               r_out_vld,   n_out_vld;
    logic [SLOT_W-1:0]  r_out_slot,  n_out_slot;
    logic               r_out_none,  n_out_none;

    // counter memory
    logic [LIMIT_W-1:0] mem [ENTRIES];
    logic [LIMIT_W-1:0] r_rd_data;
    logic               mem_we;
    logic [IW-1:0]      mem_wa;
    logic [LIMIT_W-1:0] mem_wd;
    logic               rd_en;

    logic               in_acc;
    logic [SLOT_W-1:0]  ev_slot;
    logic               ev_in_range;
    logic [LIMIT_W-1:0] cur_val;
    logic [CW-1:0]      served_inc;
    logic [IW-1:0]      idle_start;
    logic               dyn_last;
    logic [IW-1:0]      iss_next;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign ev_slot         = i_s_axis_tdata[SLOT_W-1:0];
    assign ev_in_range     = ({1'b0, ev_slot} < (SLOT_W+1)'(ENTRIES));

    // a slot never written reads as zero
    assign cur_val    = r_vld[r_pidx] ? r_rd_data : '0;
    assign served_inc = r_served + CW'(cur_val != '0);
    assign idle_start = (r_idle_ptr >= CW'(ENTRIES)) ? '0 : IW'(r_idle_ptr);
    assign dyn_last   = (r_pidx == IW'(ENTRIES - 1));
    assign iss_next   = (r_iss_addr == IW'(ENTRIES - 1)) ? '0 : IW'(r_iss_addr + 1'b1);
    assign rd_en      = ((r_state == S_DYN) || (r_state == S_IDL)) && (r_iss_left != '0);

    always_comb begin
        n_state     = r_state;
        n_vld       = r_vld;
        n_dyn_ptr   = r_dyn_ptr;
        n_idle_ptr  = r_idle_ptr;
        n_dyn_phase = r_dyn_phase;
        n_served    = r_served;
        n_iss_addr  = r_iss_addr;
        n_iss_left  = r_iss_left;
        n_pend      = 1'b0;
        n_res_slot  = r_res_slot;
        n_res_none  = r_res_none;
        n_out_vld   = r_out_vld;
        n_out_slot  = r_out_slot;
        n_out_none  = r_out_none;
        mem_we      = 1'b0;
        mem_wa      = r_pidx;
        mem_wd      = cur_val - 1'b1;

        if (r_out_vld && i_m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_s_axis_tuser) begin
                        if (ev_in_range) begin
                            mem_we            = 1'b1;
                            mem_wa            = IW'(ev_slot);
                            mem_wd            = r_limit;
                            n_vld[IW'(ev_slot)] = 1'b1;
                        end
                    end else if (r_dyn_phase) begin
                        n_state    = S_DYN;
                        n_iss_addr = r_dyn_ptr;
                        n_iss_left = CW'(ENTRIES) - CW'(r_dyn_ptr);
                    end else begin
                        n_state    = S_IDL;
                        n_iss_addr = idle_start;
                        n_iss_left = CW'(ENTRIES);
                    end
                end
            end
            S_DYN, S_IDL: begin
                // issue one read per cycle, check the word read last cycle
                n_pend = rd_en;
                if (rd_en) begin
                    n_iss_addr = iss_next;
                    n_iss_left = r_iss_left - 1'b1;
                end
                if (r_pend && (r_state == S_DYN)) begin
                    if (dyn_last) begin
                        if (served_inc < CW'(ENTRIES)) begin
                            n_dyn_phase = 1'b0;
                        end
                        n_dyn_ptr = '0;
                        n_served  = '0;
                    end else begin
                        n_dyn_ptr = IW'(r_pidx + 1'b1);
                        n_served  = served_inc;
                    end
                    if (cur_val != '0) begin
                        mem_we     = 1'b1;
                        n_res_slot = SLOT_W'(r_pidx);
                        n_res_none = 1'b0;
                        n_state    = S_OUT;
                    end else if (dyn_last) begin
                        // dynamic pass found nothing: fall back to idle scan
                        n_state    = S_IDL;
                        n_pend     = 1'b0;
                        n_iss_addr = idle_start;
                        n_iss_left = CW'(ENTRIES);
                    end
                end else if (r_pend) begin
                    if (cur_val == '0) begin
                        n_idle_ptr  = CW'(r_pidx) + CW'(1);
                        n_res_slot  = SLOT_W'(r_pidx);
                        n_res_none  = 1'b0;
                        n_dyn_phase = 1'b1;
                        n_state     = S_OUT;
                    end else if (r_iss_left == '0) begin
                        n_res_slot  = '0;
                        n_res_none  = 1'b1;
                        n_dyn_phase = 1'b1;
                        n_state     = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_vld || i_m_axis_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_slot = r_res_slot;
                    n_out_none = r_res_none;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_iss_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RST;
            r_vld       <= '0;
            r_dyn_ptr   <= '0;
            r_idle_ptr  <= '0;
            r_dyn_phase <= 1'b0;
            r_served    <= '0;
            r_iss_left  <= '0;
            r_pend      <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_vld       <= n_vld;
            r_dyn_ptr   <= n_dyn_ptr;
            r_idle_ptr  <= n_idle_ptr;
            r_dyn_phase <= n_dyn_phase;
            r_served    <= n_served;
            r_iss_left  <= n_iss_left;
            r_pend      <= n_pend;
            r_out_vld   <= n_out_vld;
        end
        r_iss_addr <= n_iss_addr;
        r_pidx     <= r_iss_addr;
        r_res_slot <= n_res_slot;
        r_res_none <= n_res_none;
        r_out_slot <= n_out_slot;
        r_out_none <= n_out_none;
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = 8'(r_out_slot);
    assign o_m_axis_tuser  = r_out_none;

endmodule

// File: dv/active_sensor_poll_scheduler_top_tb.sv
// Self-checking testbench for active_sensor_poll_scheduler_top: directed table, then
// random answer/poll traffic under several retry limits with random stalls on both streams.
// Depends on aspsch_pkg and the RTL top; results are checked against an in-bench predictor.
module active_sensor_poll_scheduler_top_tb;
    import aspsch_pkg::*;

    localparam int ENTRIES         = ENTRIES_DEF;
    localparam int CFG_SETTLE      = 80;    // drain margin, longer than the slowest request
    localparam int HOLD_AT_RESULT  = 30;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 9;
    localparam int LIMIT_RANDOM    = -1;
    localparam int LIMIT_PLAN [NUM_PHASES] = '{255, 1, 0, 2, LIMIT_RANDOM, 255,
                                               LIMIT_RANDOM, 1, LIMIT_RANDOM};

    typedef enum logic {EV_ANSWERED = 1'b0, REQ_POLL = 1'b1} t_word_kind;

    typedef struct packed {
        logic [SLOT_W-1:0] poll_slot;
        logic              none_found;
    } t_poll_result;

    typedef struct packed {
        t_word_kind        kind;
        logic [SLOT_W-1:0] slot;
        logic              fixed;    // expected result typed in below
        t_poll_result      want;
    } t_dir_row;

    localparam int DIR_ROWS = 20;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{REQ_POLL,    5'd0,  1'b1, '{5'd0,  1'b0}},   // first idle slot after reset
        '{EV_ANSWERED, 5'd31, 1'b0, '{5'd0,  1'b0}},   // out of range, ignored
        '{EV_ANSWERED, 5'd28, 1'b0, '{5'd0,  1'b0}},   // first slot past the table
        '{EV_ANSWERED, 5'd0,  1'b0, '{5'd0,  1'b0}},
        '{EV_ANSWERED, 5'd27, 1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd31, 1'b1, '{5'd0,  1'b0}},   // dynamic pass hits slot 0
        '{REQ_POLL,    5'd0,  1'b1, '{5'd27, 1'b0}},   // top slot, pass wraps short
        '{REQ_POLL,    5'd0,  1'b1, '{5'd1,  1'b0}},   // back to idle round-robin
        '{REQ_POLL,    5'd21, 1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd10, 1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}},
        '{EV_ANSWERED, 5'd21, 1'b0, '{5'd0,  1'b0}},
        '{EV_ANSWERED, 5'd10, 1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}},
        '{EV_ANSWERED, 5'd30, 1'b0, '{5'd0,  1'b0}},
        '{EV_ANSWERED, 5'd1,  1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}},
        '{REQ_POLL,    5'd0,  1'b0, '{5'd0,  1'b0}}
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_wr_data = '0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [7:0]         i_s_axis_tdata = '0;   // [4:0] sensor_slot
    logic               i_s_axis_tuser = 1'b0; // [0] kind
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [7:0]         o_m_axis_tdata;        // [4:0] poll_slot
    logic               o_m_axis_tuser;        // [0] none_found

    active_sensor_poll_scheduler_top #(
        .ENTRIES(ENTRIES)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // scheduler shadow state; pointers and count one bit wider so 32 slots fit
    logic [LIMIT_W-1:0] retry_limit_q = LIMIT_RST;
    logic [LIMIT_W-1:0] slot_retries [ENTRIES];
    logic [SLOT_W:0]    dyn_ptr = '0;
    logic [SLOT_W:0]    idle_ptr = '0;
    logic               dyn_phase = 1'b0;
    logic [SLOT_W:0]    dyn_served = '0;

    t_poll_result expected_polls [$];
    int           mismatches = 0;
    int           words_sent = 0;
    int           feed_calm = 0;
    int           sink_calm = 0;
    int           stall_cycles = 0;

    // Returns 1 when the word yields a poll result.
    function automatic bit step_scheduler(input t_word_kind kind,
                                          input logic [SLOT_W-1:0] slot,
                                          output t_poll_result res);
        logic              found;
        logic [SLOT_W-1:0] pick;
        int                p;
        int                n;
        found = 1'b0;
        pick  = '0;
        res   = '0;
        if (kind == EV_ANSWERED) begin
            if (slot < ENTRIES) slot_retries[slot] = retry_limit_q;
            return 1'b0;
        end
        if (dyn_phase) begin
            while (dyn_ptr < ENTRIES) begin
                p = dyn_ptr;
                dyn_ptr++;
                if (slot_retries[p] != 0) begin
                    slot_retries[p]--;
                    pick  = SLOT_W'(p);
                    found = 1'b1;
                    dyn_served++;
                    break;
                end
            end
            if (dyn_ptr >= ENTRIES) begin
                if (dyn_served < ENTRIES) dyn_phase = 1'b0;
                dyn_ptr    = '0;
                dyn_served = '0;
            end
        end
        if (!found) begin
            for (n = 0; n < ENTRIES; n++) begin
                if (idle_ptr >= ENTRIES) idle_ptr = '0;
                if (slot_retries[idle_ptr] == 0) begin
                    pick  = SLOT_W'(idle_ptr);
                    found = 1'b1;
                    idle_ptr++;
                    break;
                end
                idle_ptr++;
            end
            dyn_phase = 1'b1;
        end
        res.poll_slot  = found ? pick : '0;
        res.none_found = !found;
        return 1'b1;
    endfunction

    // Wait cycles before the next word; occasionally a run of back-to-back words.
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    // Entered and left at a falling edge; tvalid stays up so a following word
    // with no gap is not dropped for a step.
    task automatic send_word(input t_word_kind kind, input logic [SLOT_W-1:0] slot,
                             input bit fixed, input t_poll_result fixed_res);
        t_poll_result res;
        int           gap;
        gap = draw_gap(feed_calm);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= kind;
        i_s_axis_tdata  <= {3'b000, slot};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (step_scheduler(kind, slot, res)) expected_polls.push_back(fixed ? fixed_res : res);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Lets the block go quiet: answered events give no result, so wait out a request too.
    task automatic drain_inputs();
        i_s_axis_tvalid <= 1'b0;
        while (expected_polls.size() != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[active_sensor_poll_scheduler_top] ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : result_sink
        t_poll_result want;
        int           gap;
        int           seen;
        seen = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            // one long hold so the input side backs up behind the output register
            gap = (seen == HOLD_AT_RESULT) ? LONG_HOLD : draw_gap(sink_calm);
            if (gap > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            seen++;
            if (expected_polls.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected poll word: slot %0d none %0b",
                             o_m_axis_tdata[SLOT_W-1:0], o_m_axis_tuser);
            end else begin
                want = expected_polls.pop_front();
                if (o_m_axis_tdata[SLOT_W-1:0] !== want.poll_slot ||
                    o_m_axis_tuser !== want.none_found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("poll word %0d: expected slot %0d none %0b, got slot %0d none %0b",
                                 seen, want.poll_slot, want.none_found,
                                 o_m_axis_tdata[SLOT_W-1:0], o_m_axis_tuser);
                end
            end
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int                 i;
        int                 n;
        int                 s;
        int                 guard;
        int                 ph;
        int                 target;
        logic [LIMIT_W-1:0] lim;
        for (i = 0; i < ENTRIES; i++) slot_retries[i] = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (i = 0; i < DIR_ROWS; i++)
            send_word(DIR_TABLE[i].kind, DIR_TABLE[i].slot, DIR_TABLE[i].fixed,
                      DIR_TABLE[i].want);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_inputs();
            lim = (LIMIT_PLAN[ph] == LIMIT_RANDOM) ? LIMIT_W'($urandom_range(1, 255))
                                                   : LIMIT_W'(LIMIT_PLAN[ph]);
            i_cfg_wr_en   <= 1'b1;
            i_cfg_wr_data <= lim;
            @(negedge i_clk);
            i_cfg_wr_en   <= 1'b0;
            retry_limit_q = lim;

            target = words_sent + ITEMS_PER_PHASE;
            while (words_sent < target) begin
                case ($urandom_range(0, 3))
                    0, 1: begin
                        // mixed answers and polls, some answers out of range
                        repeat ($urandom_range(20, 40)) begin
                            if ($urandom_range(0, 99) < 55)
                                send_word(REQ_POLL, SLOT_W'($urandom), 1'b0, '0);
                            else if ($urandom_range(0, 7) == 0)
                                send_word(EV_ANSWERED, SLOT_W'($urandom_range(ENTRIES, 31)),
                                          1'b0, '0);
                            else
                                send_word(EV_ANSWERED, SLOT_W'($urandom_range(0, ENTRIES-1)),
                                          1'b0, '0);
                        end
                    end
                    2: begin
                        // partial load with the top slot, poll until a short pass
                        // leaves dynamic phase off, then fill every slot so the
                        // idle scan comes up empty
                        send_word(EV_ANSWERED, SLOT_W'(ENTRIES-1), 1'b0, '0);
                        n = $urandom_range(1, ENTRIES-1);
                        for (i = 0; i < n; i++)
                            send_word(EV_ANSWERED, SLOT_W'($urandom_range(0, ENTRIES-2)),
                                      1'b0, '0);
                        guard = 0;
                        do begin
                            send_word(REQ_POLL, SLOT_W'($urandom), 1'b0, '0);
                            guard++;
                        end while (dyn_phase && guard < 60);
                        s = $urandom_range(0, ENTRIES-1);
                        for (i = 0; i < ENTRIES; i++)
                            send_word(EV_ANSWERED, SLOT_W'((s + i) % ENTRIES), 1'b0, '0);
                        repeat ($urandom_range(2, 10))
                            send_word(REQ_POLL, SLOT_W'($urandom), 1'b0, '0);
                    end
                    default: begin
                        repeat ($urandom_range(5, 20))
                            send_word(EV_ANSWERED, SLOT_W'($urandom_range(0, ENTRIES-1)),
                                      1'b0, '0);
                        repeat ($urandom_range(5, 30))
                            send_word(REQ_POLL, SLOT_W'($urandom), 1'b0, '0);
                    end
                endcase
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (expected_polls.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        if (mismatches == 0)
            $display("[active_sensor_poll_scheduler_top] OK");
        else
            $display("[active_sensor_poll_scheduler_top] ERROR");
        $finish;
    end

endmodule
